### src/timestamp_stream_merger_defines.svh
// ---------------------------------------------------------------------------
// Timestamp stream merger assertion macros
// Shared helpers for concurrent checks in the merger RTL.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_STREAM_MERGER_DEFINES_SVH
`define TIMESTAMP_STREAM_MERGER_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define TSM_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define TSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tsm_pkg.sv
// ---------------------------------------------------------------------------
// Timestamp stream merger package
// Shared types, codes and defaults for the merger and its queue cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsm_pkg;

  localparam int MAX_STREAMS_DEF = 16;

  // Request modes
  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_REFILL  = 2'd2;

  // Result status codes
  typedef enum logic [3:0] {
    ST_EVENT      = 4'd0,
    ST_PAUSED     = 4'd1,
    ST_EXHAUSTED  = 4'd2,
    ST_ADDED      = 4'd3,
    ST_EMPTY      = 4'd4,
    ST_FULL       = 4'd5,
    ST_REFILL_OK  = 4'd6,
    ST_REFILL_BAD = 4'd7,
    ST_PENDING    = 4'd8
  } status_t;

  // Queue operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Queue entry: head timestamp plus the stream's bookkeeping
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] pos;
    logic [31:0] cnt;
    logic [1:0]  kind;
  } entry_t;

  // Broadcast control from the sequencer to the cell row
  typedef struct packed {
    op_t    op;
    entry_t ent;
  } cell_ctrl_t;

endpackage

### src/tsm_cell.sv
// ---------------------------------------------------------------------------
// Timestamp stream merger queue cell
// One slot of the sorted queue; takes its own, the new or a neighbor entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsm_cell import tsm_pkg::*; #(
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [SW-1:0] new_stream,
  input  logic          left_valid,
  input  logic          left_keep,
  input  entry_t        left_ent,
  input  logic [SW-1:0] left_stream,
  input  logic          right_valid,
  input  entry_t        right_ent,
  input  logic [SW-1:0] right_stream,
  output logic          valid,
  output entry_t        ent,
  output logic [SW-1:0] stream,
  output logic          keep
);

  logic          valid_next;
  entry_t        ent_next;
  logic [SW-1:0] stream_next;

  // Own entry stays ahead of the new one: earlier time, or same time and lower stream
  assign keep = valid && ((ent.key < ctrl.ent.key) ||
                ((ent.key == ctrl.ent.key) && (stream < new_stream)));

  // Pick the next slot content
  always_comb begin
    valid_next  = valid;
    ent_next    = ent;
    stream_next = stream;
    case (ctrl.op)
      OP_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            valid_next  = 1'b1;
            ent_next    = ctrl.ent;
            stream_next = new_stream;
          end else begin
            valid_next  = left_valid;
            ent_next    = left_ent;
            stream_next = left_stream;
          end
        end
      end
      OP_POP: begin
        valid_next  = right_valid;
        ent_next    = right_ent;
        stream_next = right_stream;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ent    <= ent_next;
    stream <= stream_next;
  end

endmodule

### src/tsm_queue.sv
// ---------------------------------------------------------------------------
// Timestamp stream merger priority queue
// A row of cells kept sorted by time and stream; the head is the minimum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timestamp_stream_merger_defines.svh"

module tsm_queue import tsm_pkg::*; #(
  parameter int DEPTH = MAX_STREAMS_DEF,
  parameter int SW    = $clog2(MAX_STREAMS_DEF)
) (
  input  logic          clk,
  input  logic          rst,
  input  cell_ctrl_t    ctrl,
  input  logic [SW-1:0] new_stream,
  output logic          head_valid,
  output entry_t        head_ent,
  output logic [SW-1:0] head_stream
);

  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] keep_vec;
  entry_t           ent_arr    [DEPTH];
  logic [SW-1:0]    stream_arr [DEPTH];

  // Chain the cells; the row ends see an empty neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          l_valid;
    logic          l_keep;
    entry_t        l_ent;
    logic [SW-1:0] l_stream;
    logic          r_valid;
    entry_t        r_ent;
    logic [SW-1:0] r_stream;

    if (i == 0) begin : g_first
      assign l_valid  = 1'b0;
      assign l_keep   = 1'b1;
      assign l_ent    = '0;
      assign l_stream = '0;
    end else begin : g_inner_l
      assign l_valid  = valid_vec[i-1];
      assign l_keep   = keep_vec[i-1];
      assign l_ent    = ent_arr[i-1];
      assign l_stream = stream_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid  = 1'b0;
      assign r_ent    = '0;
      assign r_stream = '0;
    end else begin : g_inner_r
      assign r_valid  = valid_vec[i+1];
      assign r_ent    = ent_arr[i+1];
      assign r_stream = stream_arr[i+1];
    end

    tsm_cell #(.SW(SW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_stream  (new_stream),
      .left_valid  (l_valid),
      .left_keep   (l_keep),
      .left_ent    (l_ent),
      .left_stream (l_stream),
      .right_valid (r_valid),
      .right_ent   (r_ent),
      .right_stream(r_stream),
      .valid       (valid_vec[i]),
      .ent         (ent_arr[i]),
      .stream      (stream_arr[i]),
      .keep        (keep_vec[i])
    );
  end

  assign head_valid  = valid_vec[0];
  assign head_ent    = ent_arr[0];
  assign head_stream = stream_arr[0];

  // Occupied cells form a contiguous run from the head
  `TSM_ASSERT(a_valid_prefix, clk, rst, (valid_vec & (valid_vec + DEPTH'(1))) == '0,
              "queue cells not packed toward head")

  // Head is strictly ahead of its neighbor
  `TSM_ASSERT(a_head_order, clk, rst,
              !valid_vec[1] || (ent_arr[0].key < ent_arr[1].key) ||
              ((ent_arr[0].key == ent_arr[1].key) && (stream_arr[0] < stream_arr[1])),
              "queue head out of order")

  // Pop only reaches a row with an entry at the head
  `TSM_ASSERT(a_pop_nonempty, clk, rst, (ctrl.op != OP_POP) || valid_vec[0],
              "pop issued on an empty queue")

endmodule

### src/timestamp_stream_merger.sv
// ---------------------------------------------------------------------------
// Timestamp stream merger
// Merges registered timestamp streams into one time-ordered event sequence.
// ---------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_stall  | mode, log_type, record_count, timestamp
//  out     | out_valid/out_stall| status, stream_index, record_index,
//          |                    | event_type, event_time, need_refill,
//          |                    | events_done
//  cfg     | cfg_we             | cfg_wdata (paused)
//
// Each request passes an accept state, then an execute state in which
// the cell row shifts once for an insert or a pop and the result is registered.
// Execute waits while the previous result is still held by out_stall.
// A new request is accepted while a finished result waits to be taken.
// Reset clears the cell valid bits at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timestamp_stream_merger_defines.svh"

module timestamp_stream_merger import tsm_pkg::*; #(
  parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [1:0]  log_type,
  input  logic [31:0] record_count,
  input  logic [63:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [3:0]  stream_index,
  output logic [31:0] record_index,
  output logic [1:0]  event_type,
  output logic [63:0] event_time,
  output logic        need_refill,
  output logic [63:0] events_done
);

  localparam int SW = $clog2(MAX_STREAMS);
  localparam int TW = $clog2(MAX_STREAMS + 1);

  state_t        state, state_next;
  logic          paused;
  logic [1:0]    req_mode;
  logic [1:0]    req_type;
  logic [31:0]   req_count;
  logic [63:0]   req_ts;
  logic [TW-1:0] stream_total, stream_total_next;
  logic [63:0]   delivered, delivered_next;
  logic          refill_pending, refill_pending_next;
  logic [SW-1:0] refill_stream, refill_stream_next;
  entry_t        refill_ent, refill_ent_next;

  cell_ctrl_t    q_ctrl;
  logic [SW-1:0] q_stream;
  logic          head_valid;
  entry_t        head_ent;
  logic [SW-1:0] head_stream;

  logic          accept;
  logic          exec_go;
  logic          res_valid;
  status_t       res_status;
  logic [3:0]    res_sidx;
  logic [31:0]   res_ridx;
  logic [1:0]    res_type;
  logic [63:0]   res_time;
  logic          res_need;
  logic [31:0]   pos_inc;

  assign accept  = in_valid && !in_stall;
  assign exec_go = (state == S_EXEC) && (!out_valid || !out_stall);
  assign pos_inc = head_ent.pos + 32'd1;

  // Sequencer: accept in idle, execute once the result register is free
  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  if (exec_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode the held request into a queue operation and a result beat
  always_comb begin
    res_valid           = 1'b1;
    res_status          = ST_EVENT;
    res_sidx            = '0;
    res_ridx            = '0;
    res_type            = '0;
    res_time            = '0;
    res_need            = 1'b0;
    stream_total_next   = stream_total;
    delivered_next      = delivered;
    refill_pending_next = refill_pending;
    refill_stream_next  = refill_stream;
    refill_ent_next     = refill_ent;
    q_ctrl.op           = OP_HOLD;
    q_ctrl.ent          = '{key: req_ts, pos: '0, cnt: req_count, kind: req_type};
    q_stream            = stream_total[SW-1:0];
    case (req_mode)
      MODE_ADD: begin
        if (req_count == '0) begin
          res_status = ST_EMPTY;
        end else if (stream_total >= TW'(MAX_STREAMS)) begin
          res_status = ST_FULL;
        end else begin
          res_status        = ST_ADDED;
          res_sidx          = 4'(stream_total);
          q_ctrl.op         = OP_INSERT;
          stream_total_next = stream_total + TW'(1);
        end
      end
      MODE_ADVANCE: begin
        if (paused) begin
          res_status = ST_PAUSED;
        end else if (refill_pending) begin
          res_status = ST_PENDING;
        end else if (!head_valid) begin
          res_status = ST_EXHAUSTED;
        end else begin
          res_status      = ST_EVENT;
          res_sidx        = 4'(head_stream);
          res_ridx        = head_ent.pos;
          res_type        = head_ent.kind;
          res_time        = head_ent.key;
          res_need        = (pos_inc < head_ent.cnt);
          q_ctrl.op       = OP_POP;
          delivered_next  = delivered + 64'd1;
          refill_pending_next = res_need;
          refill_stream_next  = head_stream;
          refill_ent_next     = head_ent;
          refill_ent_next.pos = pos_inc;
        end
      end
      MODE_REFILL: begin
        if (refill_pending) begin
          res_status          = ST_REFILL_OK;
          res_sidx            = 4'(refill_stream);
          q_ctrl.op           = OP_INSERT;
          q_ctrl.ent          = refill_ent;
          q_ctrl.ent.key      = req_ts;
          q_stream            = refill_stream;
          refill_pending_next = 1'b0;
        end else begin
          res_status = ST_REFILL_BAD;
        end
      end
      default: res_valid = 1'b0;
    endcase
    if (!exec_go) q_ctrl.op = OP_HOLD;
  end

  tsm_queue #(.DEPTH(MAX_STREAMS), .SW(SW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (q_ctrl),
    .new_stream (q_stream),
    .head_valid (head_valid),
    .head_ent   (head_ent),
    .head_stream(head_stream)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      paused         <= 1'b0;
      stream_total   <= '0;
      delivered      <= '0;
      refill_pending <= 1'b0;
      refill_stream  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) paused <= cfg_wdata;
      // Load a new beat, or drop the one just taken
      if (exec_go && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (exec_go) begin
        stream_total   <= stream_total_next;
        delivered      <= delivered_next;
        refill_pending <= refill_pending_next;
        refill_stream  <= refill_stream_next;
      end
    end
  end

  // Hold the request and load the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_type  <= log_type;
      req_count <= record_count;
      req_ts    <= timestamp;
    end
    if (exec_go) refill_ent <= refill_ent_next;
    if (exec_go && res_valid) begin
      status       <= res_status;
      stream_index <= res_sidx;
      record_index <= res_ridx;
      event_type   <= res_type;
      event_time   <= res_time;
      need_refill  <= res_need;
      events_done  <= delivered_next;
    end
  end

  // An accepted beat occupies the sequencer in the next cycle
  `TSM_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall,
                   "request accepted but sequencer not busy")

  // A refill request only arises from an event beat that asks for it
  `TSM_ASSERT(a_refill_from_event, clk, rst,
              !$rose(refill_pending) ||
              (out_valid && (status == ST_EVENT) && need_refill),
              "refill pending without event beat")

  // A stalled result beat holds its payload
  `TSM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(status) && $stable(events_done) &&
                   $stable(event_time) && $stable(record_index),
                   "stalled result beat changed")

endmodule
